@@ hdl/md5_pkg.sv @@
// md5_pkg: beat types, initial chaining value, round constant and rotation tables
package md5_pkg;

   // initial chaining value
   localparam logic [31:0] IV_A = 32'h67452301;
   localparam logic [31:0] IV_B = 32'hEFCDAB89;
   localparam logic [31:0] IV_C = 32'h98BADCFE;
   localparam logic [31:0] IV_D = 32'h10325476;

   // first pad byte after the message
   localparam logic [7:0] PAD_BYTE = 8'h80;

   // fill level at which the length field starts
   localparam logic [5:0] LEN_START = 6'd56;
   // last byte slot of a block
   localparam logic [5:0] LAST_SLOT = 6'd63;
   // last round of a compression
   localparam logic [5:0] LAST_ROUND = 6'd63;
   // last byte of the length field
   localparam logic [2:0] LAST_LEN_BYTE = 3'd7;
   // most bytes one input word carries
   localparam logic [2:0] MAX_BYTES = 3'd4;

   // input beat
   typedef struct packed {
      logic [31:0] data_word;
      logic [2:0]  byte_count;
      logic        last_word;
   } req_type;

   // result beat
   typedef struct packed {
      logic [31:0] digest_word_a;
      logic [31:0] digest_word_b;
      logic [31:0] digest_word_c;
      logic [31:0] digest_word_d;
   } rsp_type;

   // additive constant of each round
   function automatic logic [31:0] round_const(input logic [5:0] r);
      logic [31:0] k;
      case (r)
         6'd0:  k = 32'hd76aa478;
         6'd1:  k = 32'he8c7b756;
         6'd2:  k = 32'h242070db;
         6'd3:  k = 32'hc1bdceee;
         6'd4:  k = 32'hf57c0faf;
         6'd5:  k = 32'h4787c62a;
         6'd6:  k = 32'ha8304613;
         6'd7:  k = 32'hfd469501;
         6'd8:  k = 32'h698098d8;
         6'd9:  k = 32'h8b44f7af;
         6'd10: k = 32'hffff5bb1;
         6'd11: k = 32'h895cd7be;
         6'd12: k = 32'h6b901122;
         6'd13: k = 32'hfd987193;
         6'd14: k = 32'ha679438e;
         6'd15: k = 32'h49b40821;
         6'd16: k = 32'hf61e2562;
         6'd17: k = 32'hc040b340;
         6'd18: k = 32'h265e5a51;
         6'd19: k = 32'he9b6c7aa;
         6'd20: k = 32'hd62f105d;
         6'd21: k = 32'h02441453;
         6'd22: k = 32'hd8a1e681;
         6'd23: k = 32'he7d3fbc8;
         6'd24: k = 32'h21e1cde6;
         6'd25: k = 32'hc33707d6;
         6'd26: k = 32'hf4d50d87;
         6'd27: k = 32'h455a14ed;
         6'd28: k = 32'ha9e3e905;
         6'd29: k = 32'hfcefa3f8;
         6'd30: k = 32'h676f02d9;
         6'd31: k = 32'h8d2a4c8a;
         6'd32: k = 32'hfffa3942;
         6'd33: k = 32'h8771f681;
         6'd34: k = 32'h6d9d6122;
         6'd35: k = 32'hfde5380c;
         6'd36: k = 32'ha4beea44;
         6'd37: k = 32'h4bdecfa9;
         6'd38: k = 32'hf6bb4b60;
         6'd39: k = 32'hbebfbc70;
         6'd40: k = 32'h289b7ec6;
         6'd41: k = 32'heaa127fa;
         6'd42: k = 32'hd4ef3085;
         6'd43: k = 32'h04881d05;
         6'd44: k = 32'hd9d4d039;
         6'd45: k = 32'he6db99e5;
         6'd46: k = 32'h1fa27cf8;
         6'd47: k = 32'hc4ac5665;
         6'd48: k = 32'hf4292244;
         6'd49: k = 32'h432aff97;
         6'd50: k = 32'hab9423a7;
         6'd51: k = 32'hfc93a039;
         6'd52: k = 32'h655b59c3;
         6'd53: k = 32'h8f0ccc92;
         6'd54: k = 32'hffeff47d;
         6'd55: k = 32'h85845dd1;
         6'd56: k = 32'h6fa87e4f;
         6'd57: k = 32'hfe2ce6e0;
         6'd58: k = 32'ha3014314;
         6'd59: k = 32'h4e0811a1;
         6'd60: k = 32'hf7537e82;
         6'd61: k = 32'hbd3af235;
         6'd62: k = 32'h2ad7d2bb;
         default: k = 32'heb86d391;
      endcase
      return k;
   endfunction

   // left rotation amount, indexed by phase and round within group of four
   function automatic logic [4:0] rot_amount(input logic [3:0] idx);
      logic [4:0] s;
      case (idx)
         4'd0:  s = 5'd7;
         4'd1:  s = 5'd12;
         4'd2:  s = 5'd17;
         4'd3:  s = 5'd22;
         4'd4:  s = 5'd5;
         4'd5:  s = 5'd9;
         4'd6:  s = 5'd14;
         4'd7:  s = 5'd20;
         4'd8:  s = 5'd4;
         4'd9:  s = 5'd11;
         4'd10: s = 5'd16;
         4'd11: s = 5'd23;
         4'd12: s = 5'd6;
         4'd13: s = 5'd10;
         4'd14: s = 5'd15;
         default: s = 5'd21;
      endcase
      return s;
   endfunction

endpackage

@@ hdl/md5_message_digest_top.sv @@
// md5_message_digest_top: md5 engine fed by 32-bit message words
//
//  channel  direction  handshake          payload
//  req      in         req_valid/stall    md5_pkg::req_type (word, byte count, last)
//  rsp      out        rsp_valid/stall    md5_pkg::rsp_type (four digest words)
//
// a beat's valid bytes enter the block buffer one byte per cycle, pausing while a full block
// is compressed: 64 rounds through the one round unit, then one fold; req_stall stays high
// until the beat is done. a last beat then pushes the 0x80 pad byte, zero bytes up to byte 56,
// eight length bytes and the final block(s), then loads the digest into the output register.
// reset restores the initial chaining value and clears the length and fill count.
// the digest sits in an output register; a stalled rsp holds back only the next digest.
module md5_message_digest_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  md5_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output md5_pkg::rsp_type rsp_payload
);
   import md5_pkg::*;

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_BYTES = 7'b0000010,
      S_PAD   = 7'b0000100,
      S_LEN   = 7'b0001000,
      S_ROUND = 7'b0010000,
      S_FOLD  = 7'b0100000,
      S_EMIT  = 7'b1000000
   } state_type;

   state_type   state_ff, state_in;
   state_type   ret_ff, ret_in;
   state_type   ret_next;
   logic [31:0] chain_ff [4];
   logic [31:0] chain_in [4];
   logic [31:0] block_ff [16];
   logic [31:0] block_in [16];
   logic [63:0] bitlen_ff, bitlen_in;
   logic [5:0]  fill_ff, fill_in;
   logic [31:0] word_ff, word_in;
   logic [2:0]  cnt_ff, cnt_in;
   logic        last_ff, last_in;
   logic        pad_first_ff, pad_first_in;
   logic [2:0]  len_idx_ff, len_idx_in;
   logic [5:0]  round_ff, round_in;
   logic [31:0] wa_ff, wa_in;
   logic [31:0] wb_ff, wb_in;
   logic [31:0] wc_ff, wc_in;
   logic [31:0] wd_ff, wd_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;
   logic        push_en;
   logic [7:0]  push_byte;
   logic [3:0]  word_idx;
   logic [31:0] new_b;

   // shared round unit
   md5_round u_round (
      .round_idx (round_ff),
      .a_val     (wa_ff),
      .b_val     (wb_ff),
      .c_val     (wc_ff),
      .d_val     (wd_ff),
      .msg_word  (block_ff[word_idx]),
      .word_idx  (word_idx),
      .new_b     (new_b)
   );

   assign req_stall   = (state_ff != S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      ret_in       = ret_ff;
      ret_next     = ret_ff;
      chain_in     = chain_ff;
      block_in     = block_ff;
      bitlen_in    = bitlen_ff;
      fill_in      = fill_ff;
      word_in      = word_ff;
      cnt_in       = cnt_ff;
      last_in      = last_ff;
      pad_first_in = pad_first_ff;
      len_idx_in   = len_idx_ff;
      round_in     = round_ff;
      wa_in        = wa_ff;
      wb_in        = wb_ff;
      wc_in        = wc_ff;
      wd_in        = wd_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      push_en      = 1'b0;
      push_byte    = 8'h00;

      // result beat taken
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               word_in  = req_payload.data_word;
               cnt_in   = (req_payload.byte_count > MAX_BYTES) ? MAX_BYTES
                                                               : req_payload.byte_count;
               last_in  = req_payload.last_word;
               state_in = S_BYTES;
            end
         end
         S_BYTES: begin
            if (cnt_ff != 3'd0) begin
               push_en   = 1'b1;
               push_byte = word_ff[7:0];
               word_in   = word_ff >> 8;
               cnt_in    = cnt_ff - 3'd1;
               bitlen_in = bitlen_ff + 64'd8;
               ret_next  = S_BYTES;
            end else if (last_ff) begin
               pad_first_in = 1'b1;
               state_in     = S_PAD;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_PAD: begin
            if (pad_first_ff) begin
               push_en      = 1'b1;
               push_byte    = PAD_BYTE;
               pad_first_in = 1'b0;
               ret_next     = S_PAD;
            end else if (fill_ff == LEN_START) begin
               len_idx_in = 3'd0;
               state_in   = S_LEN;
            end else begin
               push_en  = 1'b1;
               ret_next = S_PAD;
            end
         end
         S_LEN: begin
            push_en    = 1'b1;
            push_byte  = bitlen_ff[{len_idx_ff, 3'b000} +: 8];
            len_idx_in = len_idx_ff + 3'd1;
            ret_next   = (len_idx_ff == LAST_LEN_BYTE) ? S_EMIT : S_LEN;
         end
         S_ROUND: begin
            wa_in    = wd_ff;
            wb_in    = new_b;
            wc_in    = wb_ff;
            wd_in    = wc_ff;
            round_in = round_ff + 6'd1;
            if (round_ff == LAST_ROUND) begin
               state_in = S_FOLD;
            end
         end
         S_FOLD: begin
            chain_in[0] = chain_ff[0] + wa_ff;
            chain_in[1] = chain_ff[1] + wb_ff;
            chain_in[2] = chain_ff[2] + wc_ff;
            chain_in[3] = chain_ff[3] + wd_ff;
            state_in    = ret_ff;
         end
         S_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.digest_word_a = chain_ff[0];
               rsp_data_in.digest_word_b = chain_ff[1];
               rsp_data_in.digest_word_c = chain_ff[2];
               rsp_data_in.digest_word_d = chain_ff[3];
               chain_in[0]               = IV_A;
               chain_in[1]               = IV_B;
               chain_in[2]               = IV_C;
               chain_in[3]               = IV_D;
               bitlen_in                 = 64'd0;
               fill_in                   = 6'd0;
               state_in                  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // byte into the buffer, compression when the block fills
      if (push_en) begin
         block_in[fill_ff[5:2]][{fill_ff[1:0], 3'b000} +: 8] = push_byte;
         fill_in = fill_ff + 6'd1;
         if (fill_ff == LAST_SLOT) begin
            ret_in   = ret_next;
            round_in = 6'd0;
            wa_in    = chain_ff[0];
            wb_in    = chain_ff[1];
            wc_in    = chain_ff[2];
            wd_in    = chain_ff[3];
            state_in = S_ROUND;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ret_ff       <= S_IDLE;
         chain_ff[0]  <= IV_A;
         chain_ff[1]  <= IV_B;
         chain_ff[2]  <= IV_C;
         chain_ff[3]  <= IV_D;
         bitlen_ff    <= 64'd0;
         fill_ff      <= 6'd0;
         cnt_ff       <= 3'd0;
         last_ff      <= 1'b0;
         pad_first_ff <= 1'b0;
         len_idx_ff   <= 3'd0;
         round_ff     <= 6'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         chain_ff     <= chain_in;
         bitlen_ff    <= bitlen_in;
         fill_ff      <= fill_in;
         cnt_ff       <= cnt_in;
         last_ff      <= last_in;
         pad_first_ff <= pad_first_in;
         len_idx_ff   <= len_idx_in;
         round_ff     <= round_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload and working registers
   always_ff @(posedge clock) begin
      block_ff    <= block_in;
      word_ff     <= word_in;
      wa_ff       <= wa_in;
      wb_ff       <= wb_in;
      wc_ff       <= wc_in;
      wd_ff       <= wd_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

@@ hdl/md5_round.sv @@
// md5_round: one md5 round step, shared by all 64 rounds of a compression
module md5_round (
   input  logic [5:0]  round_idx,
   input  logic [31:0] a_val,
   input  logic [31:0] b_val,
   input  logic [31:0] c_val,
   input  logic [31:0] d_val,
   input  logic [31:0] msg_word,
   output logic [3:0]  word_idx,
   output logic [31:0] new_b
);
   import md5_pkg::*;

   logic [3:0]  r4;
   logic [31:0] f_val;
   logic [31:0] t_sum;
   logic [63:0] rot_wide;
   logic [4:0]  shift;

   assign r4 = round_idx[3:0];

   // mixing function and message word schedule per phase
   always_comb begin
      case (round_idx[5:4])
         2'd0: begin
            f_val    = (b_val & c_val) | (~b_val & d_val);
            word_idx = r4;
         end
         2'd1: begin
            f_val    = (b_val & d_val) | (c_val & ~d_val);
            word_idx = (r4 << 2) + r4 + 4'd1;
         end
         2'd2: begin
            f_val    = b_val ^ c_val ^ d_val;
            word_idx = (r4 << 1) + r4 + 4'd5;
         end
         default: begin
            f_val    = c_val ^ (b_val | ~d_val);
            word_idx = (r4 << 3) - r4;
         end
      endcase
   end

   // sum, rotate and add
   assign shift    = rot_amount({round_idx[5:4], round_idx[1:0]});
   assign t_sum    = a_val + f_val + msg_word + round_const(round_idx);
   assign rot_wide = {t_sum, t_sum} << shift;
   assign new_b    = b_val + rot_wide[63:32];

endmodule
